### sv/dtq_pkg.sv
// Shared types and constants for the deadline timer queue.
package dtq_pkg;

    localparam int TIME_W      = 48;
    localparam int DUR_W       = 32;
    localparam int HID_W       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int EMIT_CW     = $clog2(MAX_RESULTS);

    localparam logic FUNC_SCHED      = 1'b0;
    localparam logic FUNC_TICK       = 1'b1;
    localparam logic STATUS_EXPIRED  = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef struct packed {
        logic             func;
        logic [DUR_W-1:0] duration;
        logic [HID_W-1:0] handle_id;
    } t_req;

    typedef struct packed {
        logic [HID_W-1:0] expired_handle;
        logic             status;
        logic             last;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_EMIT,
        ST_REJECT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_sched;
        logic load_tick;
        logic insert;
        logic emit;
        logic reject;
        logic last;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic head_due;
        logic next_due;
        logic out_free;
    } t_stat;

endpackage

### sv/deadline_timer_queue_core.sv
// Top level of the deadline timer queue: controller plus datapath.
// Usage:
//   Input channel (i_valid/o_stall, payload i_req) takes schedule and tick
//   requests; output channel (o_valid/i_stall, payload o_rsp) returns
//   expired handles and queue-full rejections.
//   A schedule request with a non-null handle first forms now + duration;
//   then the sorted shift-register queue inserts it if not full.
//   A null-handle schedule gives nothing.
//   A tick first advances time, then, while the output register is free,
//   pops one due entry per cycle into the output register, earliest
//   deadline first, at most 16 per tick, last set on the final one; a tick
//   with nothing due gives no result. A rejection gives one, last set.
//   Unless stalled, the single output register gives one result per cycle.
//   o_stall is high whenever a request is in progress; the next request is
//   taken once the current one is done or has placed its final result.
//   When the receiver stalls, the result holds in the output register and
//   the run waits until it is taken.
//   Synchronous reset empties the queue, clears time to zero and drops any
//   pending result.
module deadline_timer_queue_core
    import dtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    t_cmd  cmd;
    t_stat stat;

    dtq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    dtq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_rsp   (o_rsp),
        .i_stall (i_stall)
    );

endmodule

### sv/dtq_ctrl.sv
// Controller state machine: sequences schedule, reject and expiry runs.
module dtq_ctrl
    import dtq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_req  i_req,
    output logic  o_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state             r_state;
    t_state             n_state;
    logic [EMIT_CW-1:0] r_emit_cnt;
    logic               accept;
    logic               is_tick;
    logic               hid_nz;
    logic               run_end;

    assign accept  = i_valid && (r_state == ST_IDLE);
    assign is_tick = (i_req.func == FUNC_TICK);
    assign hid_nz  = (i_req.handle_id != '0);
    assign o_stall = (r_state != ST_IDLE);

    // Final result of a run: nothing more due, or the per-tick limit reached
    assign run_end = !i_stat.next_due || (r_emit_cnt == EMIT_CW'(MAX_RESULTS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (is_tick) begin
                        n_state = ST_EMIT;
                    end else if (hid_nz) begin
                        n_state = i_stat.full ? ST_REJECT : ST_INSERT;
                    end
                end
            end
            ST_INSERT: begin
                n_state = ST_IDLE;
            end
            ST_REJECT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                // Leave at once when nothing is due; otherwise after the final pop
                if (!i_stat.head_due || (i_stat.out_free && run_end)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.load_sched = accept && !is_tick && hid_nz;
        o_cmd.load_tick  = accept && is_tick;
        o_cmd.insert     = (r_state == ST_INSERT);
        o_cmd.reject     = (r_state == ST_REJECT) && i_stat.out_free;
        o_cmd.emit       = (r_state == ST_EMIT) && i_stat.out_free && i_stat.head_due;
        o_cmd.last       = run_end;
    end

    // Hold state and count results of the current run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_emit_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_tick) begin
                r_emit_cnt <= '0;
            end else if (o_cmd.emit) begin
                r_emit_cnt <= r_emit_cnt + EMIT_CW'(1);
            end
        end
    end

endmodule

### sv/dtq_datapath.sv
// Datapath: time counter, sorted shift-register queue and output register.
module dtq_datapath
    import dtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_req  i_req,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output logic  o_valid,
    output t_rsp  o_rsp,
    input  logic  i_stall
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_dl  [QUEUE_DEPTH];
    logic [HID_W-1:0]  r_hid [QUEUE_DEPTH];
    logic [CW-1:0]     r_count;
    logic [TIME_W-1:0] r_new_dl;
    logic [HID_W-1:0]  r_new_hid;
    logic              r_out_valid;
    t_rsp              r_out;
    logic [QUEUE_DEPTH-1:0] le;

    // Per-cell compare: entry is valid and due no later than the new deadline
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            le[i] = (CW'(i) < r_count) && (r_dl[i] <= r_new_dl);
        end
    end

    // Queue cells: insert shifts right behind the slot, pop shifts left
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic take_new;
        if (g == 0) begin : g_first
            assign take_new = 1'b1;
        end else begin : g_rest
            assign take_new = le[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.insert && !le[g]) begin
                if (take_new) begin
                    r_dl[g]  <= r_new_dl;
                    r_hid[g] <= r_new_hid;
                end else if (g > 0) begin
                    r_dl[g]  <= r_dl[(g > 0) ? g - 1 : 0];
                    r_hid[g] <= r_hid[(g > 0) ? g - 1 : 0];
                end
            end else if (i_cmd.emit && (g < QUEUE_DEPTH - 1)) begin
                r_dl[g]  <= r_dl[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                r_hid[g] <= r_hid[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
            end
        end
    end

    // Time counter and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now   <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.load_tick) begin
                r_now <= r_now + TIME_W'(1);
            end
            if (i_cmd.insert) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.emit) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Latch the new deadline and handle of a schedule request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sched) begin
            r_new_dl  <= r_now + TIME_W'(i_req.duration);
            r_new_hid <= i_req.handle_id;
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.reject || i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.reject) begin
            r_out.expired_handle <= r_new_hid;
            r_out.status         <= STATUS_REJECTED;
            r_out.last           <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out.expired_handle <= r_hid[0];
            r_out.status         <= STATUS_EXPIRED;
            r_out.last           <= i_cmd.last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    // Status to the controller
    assign o_stat.full     = (r_count == CW'(QUEUE_DEPTH));
    assign o_stat.head_due = (r_count != '0) && (r_dl[0] <= r_now);
    assign o_stat.next_due = (r_count > CW'(1)) && (r_dl[1] <= r_now);
    assign o_stat.out_free = !r_out_valid || !i_stall;

    // Queue never overfills, pops only when non-empty
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> (r_count != CW'(QUEUE_DEPTH)))
        else $error("insert into full queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not shrink queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.reject) |-> o_stat.out_free)
        else $error("result loaded over a waiting result");

endmodule
